// File: rtl/i3dl_pkg.sv
// ----------------------------------------------------------------------------
// i3dl_pkg: shared types and constants of the 3D line cell walker
// Coordinate widths, stream word widths, item modes and the per-axis control.
// ----------------------------------------------------------------------------
package i3dl_pkg;

    // Width of one cell coordinate.
    localparam int COORD_BITS = 20;

    // Signed error term: it stays within about [-span/2, 3*span/2 + 1].
    localparam int ERR_BITS = COORD_BITS + 2;

    // Input word: from_x, from_y, from_z, to_x, to_y, to_z, padded to bytes.
    localparam int IN_DATA_BITS = ((6 * COORD_BITS + 7) / 8) * 8;

    // Output word: cell_x, cell_y, cell_z, padded to bytes.
    localparam int OUT_DATA_BITS = ((3 * COORD_BITS + 7) / 8) * 8;

    // Kind of an input word.
    typedef enum logic {
        MODE_START = 1'b0,
        MODE_STEP  = 1'b1
    } t_mode;

    // Control of one axis for the current cycle.
    typedef struct packed {
        logic load;
        logic step;
    } t_axis_ctrl;

endpackage

// File: rtl/i3dl_axis.sv
// ----------------------------------------------------------------------------
// i3dl_axis: one axis of the 3D line cell walker
// Holds position, delta, direction and error of one axis and does its step.
// ----------------------------------------------------------------------------
module i3dl_axis import i3dl_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_axis_ctrl            i_ctrl,
    input  logic [COORD_BITS-1:0] i_from,
    input  logic [COORD_BITS-1:0] i_to,
    input  logic [COORD_BITS-1:0] i_span,
    output logic [COORD_BITS-1:0] o_new_delta,
    output logic [COORD_BITS-1:0] o_next_pos
);

    logic [COORD_BITS-1:0]      r_pos;
    logic [COORD_BITS-1:0]      r_delta;
    logic                       r_neg;
    logic signed [ERR_BITS-1:0] r_err;
    logic signed [ERR_BITS-1:0] n_err;
    logic signed [ERR_BITS-1:0] w_sum;
    logic signed [ERR_BITS:0]   w_twice;
    logic signed [ERR_BITS:0]   w_span_ext;
    logic                       w_move;
    logic                       w_load_neg;

    // Setup on a start word.
    assign w_load_neg  = i_to < i_from;
    assign o_new_delta = w_load_neg ? (i_from - i_to) : (i_to - i_from);

    // One Bresenham step: add delta, move when twice the error reaches span.
    assign w_sum      = r_err + $signed({2'b00, r_delta});
    assign w_twice    = {w_sum, 1'b0};
    assign w_span_ext = $signed({3'b000, i_span});
    assign w_move     = w_twice >= w_span_ext;
    assign n_err      = w_move ? (w_sum - $signed({2'b00, i_span})) : w_sum;
    assign o_next_pos = !w_move ? r_pos :
                        (r_neg ? (r_pos - COORD_BITS'(1)) : (r_pos + COORD_BITS'(1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_delta <= '0;
            r_neg   <= 1'b0;
            r_err   <= '0;
        end else if (i_ctrl.load) begin
            r_pos   <= i_from;
            r_delta <= o_new_delta;
            r_neg   <= w_load_neg;
            r_err   <= '0;
        end else if (i_ctrl.step) begin
            r_pos   <= o_next_pos;
            r_err   <= n_err;
        end
    end

endmodule

// File: rtl/integer_3d_line_cells_unit.sv
// ----------------------------------------------------------------------------
// integer_3d_line_cells_unit: integer 3D line cell walker
// Lists the grid cells strictly between two endpoints, one cell per word.
// ----------------------------------------------------------------------------
// Usage. Words come in on the slave stream. A start word (tuser = 0) carries
// both endpoints in tdata and sets up a new line, abandoning any line in
// progress. A step word (tuser = 1) advances the line by one cell. Every input
// word gives exactly one output word on the master stream: tdata holds the
// cell coordinates, tuser says whether a cell is carried (zero coordinates
// otherwise) and tlast marks that the line has no cells left. A start word
// answers with no cell and tlast set only for an empty run (equal endpoints
// or a largest delta of one); a step with no line in progress answers with no
// cell and tlast set.
// From acceptance, the word is first held in the input register; then the step
// logic of the three axes writes the line state and the output register
// together, and the output register shows the answer on the master stream.
// Throughput is one word per cycle while the receiver takes the output words,
// limited by the single add, compare and subtract per axis that feeds the
// state registers back to themselves.
// Reset (synchronous, active low) empties both registers and leaves no line
// in progress. When the receiver stalls, the output word holds, the input
// register fills, and tready drops until the output word is taken.
// ----------------------------------------------------------------------------
module integer_3d_line_cells_unit import i3dl_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Slave stream.
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    // tdata from bit 0 up: from_x, from_y, from_z, to_x, to_y, to_z.
    input  logic [IN_DATA_BITS-1:0]  i_s_tdata,
    // tuser: mode (0 = start a line, 1 = step one cell).
    input  logic                     i_s_tuser,
    // Master stream.
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    // tdata from bit 0 up: cell_x, cell_y, cell_z, zero padding.
    output logic [OUT_DATA_BITS-1:0] o_m_tdata,
    // tuser: cell_valid.
    output logic                     o_m_tuser,
    // tlast: run_done.
    output logic                     o_m_tlast
);

    // Input register.
    logic                    r_in_valid;
    t_mode                   r_in_mode;
    logic [IN_DATA_BITS-1:0] r_in_data;

    // Line state shared by the axes.
    logic [COORD_BITS-1:0] r_span;
    logic [COORD_BITS-1:0] r_count;
    logic                  r_active;
    logic [COORD_BITS-1:0] n_span;
    logic [COORD_BITS-1:0] n_count;
    logic                  n_active;

    // Output register.
    logic                     r_out_valid;
    logic [OUT_DATA_BITS-1:0] r_out_data;
    logic                     r_out_cell;
    logic                     r_out_done;
    logic [OUT_DATA_BITS-1:0] n_out_data;
    logic                     n_out_cell;
    logic                     n_out_done;

    logic                  w_advance;
    t_axis_ctrl            w_ctrl;
    logic [COORD_BITS-1:0] w_from [3];
    logic [COORD_BITS-1:0] w_to   [3];
    logic [COORD_BITS-1:0] w_delta [3];
    logic [COORD_BITS-1:0] w_next  [3];
    logic [COORD_BITS-1:0] w_biggest;
    logic [COORD_BITS-1:0] w_count_inc;
    logic                  w_last;

    // The held word moves on when the output register is free or being taken.
    assign w_advance  = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_advance;

    assign w_ctrl.load = w_advance && (r_in_mode == MODE_START);
    assign w_ctrl.step = w_advance && (r_in_mode == MODE_STEP) && r_active;

    for (genvar a = 0; a < 3; a++) begin : g_axis
        assign w_from[a] = r_in_data[a*COORD_BITS +: COORD_BITS];
        assign w_to[a]   = r_in_data[(a+3)*COORD_BITS +: COORD_BITS];

        i3dl_axis u_axis (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_from      (w_from[a]),
            .i_to        (w_to[a]),
            .i_span      (r_span),
            .o_new_delta (w_delta[a]),
            .o_next_pos  (w_next[a])
        );
    end

    // Largest delta of a new line sets its span.
    always_comb begin
        w_biggest = w_delta[0];
        if (w_delta[1] > w_biggest) begin
            w_biggest = w_delta[1];
        end
        if (w_delta[2] > w_biggest) begin
            w_biggest = w_delta[2];
        end
    end

    assign w_count_inc = r_count + COORD_BITS'(1);
    assign w_last      = w_count_inc >= r_span;

    // Next line state and next output word.
    always_comb begin
        n_span     = r_span;
        n_count    = r_count;
        n_active   = r_active;
        n_out_data = '0;
        n_out_cell = 1'b0;
        n_out_done = 1'b1;
        case (r_in_mode)
            MODE_START: begin
                n_span     = (w_biggest != '0) ? (w_biggest - COORD_BITS'(1)) : '0;
                n_count    = '0;
                n_active   = n_span != '0;
                n_out_done = !n_active;
            end
            MODE_STEP: begin
                if (r_active) begin
                    n_count    = w_count_inc;
                    n_active   = !w_last;
                    n_out_data = OUT_DATA_BITS'({w_next[2], w_next[1], w_next[0]});
                    n_out_cell = 1'b1;
                    n_out_done = w_last;
                end
            end
            default: begin
                n_out_done = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_mode <= t_mode'(i_s_tuser);
            r_in_data <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_span   <= '0;
            r_count  <= '0;
            r_active <= 1'b0;
        end else if (w_advance) begin
            r_span   <= n_span;
            r_count  <= n_count;
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data <= n_out_data;
            r_out_cell <= n_out_cell;
            r_out_done <= n_out_done;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_cell;
    assign o_m_tlast  = r_out_done;

`ifndef SYNTHESIS
    // A line in progress always has a nonzero span.
    a_active_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_span != '0))
        else $error("active line with zero span");

    // A line in progress has not yet emitted all of its cells.
    a_count_below_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_count < r_span))
        else $error("cell count reached span on an active line");

    // A shown word without a cell carries zero coordinates.
    a_empty_word_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0))
        else $error("word without a cell has nonzero coordinates");

    // A shown cell that is not the last one leaves the line in progress.
    a_cell_keeps_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser && !o_m_tlast) |-> r_active)
        else $error("line ended without a last cell");
`endif

endmodule
